// ----- hw/rtl/bmg_pkg.sv -----
// Shared types and constants for the Box-Muller Gaussian generator.
// No dependencies; imported by the core, the rotator and the checker.
package bmg_pkg;

    typedef struct packed {
        logic [31:0] uniform_a;
        logic [31:0] uniform_b;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               from_cache;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_LOG,
        S_WMUL,
        S_SQRT,
        S_XMUL,
        S_ROT,
        S_SMUL,
        S_EMIT
    } t_state;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_OFFSET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_SCALE = 2'd1;

    localparam logic [15:0] MEAN_RESET  = 16'd0;
    localparam logic [15:0] SCALE_RESET = 16'd256;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam logic [30:0] TWO_LN2_Q30   = 31'd1488522236;
    localparam logic [29:0] INV_GAIN_Q30  = 30'd652032874;

    localparam int unsigned ATAN_ENTRIES = 24;
    localparam int unsigned ATAN_IDX_W   = 5;

    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ----- hw/rtl/bmg_cordic.sv -----
// Iterative CORDIC rotator: one shift-add micro-rotation per cycle.
// Depends on bmg_pkg for the arctangent table.
module bmg_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_x0,
    input  logic [29:0]        i_angle,
    output logic               o_done,
    output logic signed [17:0] o_cos,
    output logic signed [17:0] o_sin
);
    import bmg_pkg::*;

    logic                  r_busy, r_done;
    logic [ATAN_IDX_W-1:0] r_cnt;
    logic signed [33:0]    r_x, r_y;
    logic signed [31:0]    r_z;
    logic signed [33:0]    w_xs, w_ys, w_xr, w_yr;
    logic signed [31:0]    w_atan;

    assign w_xs   = r_x >>> r_cnt;
    assign w_ys   = r_y >>> r_cnt;
    assign w_atan = $signed(ATAN_TURNS[r_cnt]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_x0;
                r_y    <= '0;
                r_z    <= $signed({2'b00, i_angle});
            end else if (r_busy) begin
                if (!r_z[31]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end
                if (r_cnt == ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign w_xr   = r_x + 34'sd32768;
    assign w_yr   = r_y + 34'sd32768;
    assign o_cos  = w_xr[33:16];
    assign o_sin  = w_yr[33:16];
    assign o_done = r_done;

endmodule

// ----- hw/rtl/box_muller_gaussian_generator_core.sv -----
// Channel | dir | handshake                  | payload
// in      | in  | i_in_valid / o_in_ready    | i_in_item  (bmg_pkg::t_in_item)
// out     | out | o_out_valid / i_out_ready  | o_out_item (bmg_pkg::t_out_item)
// cfg     | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A generating item passes through normalization, 16 log2 squarings, 16 square root
// steps, CORDIC_STEPS rotations, then scaling. A cached item goes straight to scaling.
// One item at a time; o_in_ready is high only when idle. Synchronous active-low reset.
// Depends on bmg_pkg and bmg_cordic.
module box_muller_gaussian_generator_core #(
    parameter int UNIFORM_BITS = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bmg_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bmg_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bmg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import bmg_pkg::*;

    localparam logic [31:0] USE_MASK = ~((32'd1 << (32 - UNIFORM_BITS)) - 32'd1);

    t_state r_state, n_state;

    logic [15:0]        r_mean, r_scale;
    logic [15:0]        r_cache;
    logic               r_cache_valid;
    logic [31:0]        r_u;
    logic [1:0]         r_quad;
    logic [29:0]        r_angle;
    logic [4:0]         r_cnt, r_lz;
    logic [30:0]        r_m;
    logic [15:0]        r_frac;
    logic [31:0]        r_rem, r_res, r_bit;
    logic signed [15:0] r_z;
    logic               r_from_cache;
    logic signed [32:0] r_prod;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic [31:0]        w_ua, w_ub;
    logic               w_accept, w_out_free;
    logic [5:0]         w_amt;
    logic [31:0]        w_u_next;
    logic [4:0]         w_lz_next;
    logic [61:0]        w_sq;
    logic [5:0]         w_ip;
    logic [21:0]        w_t;
    logic [52:0]        w_wprod;
    logic [31:0]        w_trial;
    logic [45:0]        w_xprod;
    logic signed [33:0] w_x0;
    logic               w_cstart, w_cdone;
    logic signed [17:0] w_cx, w_sy;
    logic signed [18:0] w_c, w_s;
    logic signed [33:0] w_round;
    logic signed [31:0] w_sample;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    assign w_ua       = i_in_item.uniform_a & USE_MASK;
    assign w_ub       = i_in_item.uniform_b & USE_MASK;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_amt     = 6'd16 >> r_cnt;
    assign w_u_next  = ((r_u >> (6'd32 - w_amt)) == 32'd0) ? (r_u << w_amt) : r_u;
    assign w_lz_next = ((r_u >> (6'd32 - w_amt)) == 32'd0) ? (r_lz + w_amt[4:0]) : r_lz;

    assign w_sq    = 62'(r_m) * 62'(r_m);
    assign w_ip    = {1'b0, r_lz} + 6'd1;
    assign w_t     = {w_ip, 16'd0} - {6'd0, r_frac};
    assign w_wprod = 53'(w_t) * 53'(TWO_LN2_Q30);
    assign w_trial = r_res + r_bit;
    assign w_xprod = 46'(r_res[15:0]) * 46'(INV_GAIN_Q30);
    assign w_x0    = $signed({2'b00, w_xprod[45:14]});
    assign w_cstart = (r_state == S_XMUL);

    bmg_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_cstart),
        .i_x0   (w_x0),
        .i_angle(r_angle),
        .o_done (w_cdone),
        .o_cos  (w_cx),
        .o_sin  (w_sy)
    );

    always_comb begin
        case (r_quad)
            QUAD_0: begin
                w_c = 19'(w_cx);
                w_s = 19'(w_sy);
            end
            QUAD_1: begin
                w_c = -19'(w_sy);
                w_s = 19'(w_cx);
            end
            QUAD_2: begin
                w_c = -19'(w_cx);
                w_s = -19'(w_sy);
            end
            default: begin
                w_c = 19'(w_sy);
                w_s = -19'(w_cx);
            end
        endcase
    end

    assign w_round  = {r_prod[32], r_prod} + 34'sd2048;
    assign w_sample = $signed({{10{w_round[33]}}, w_round[33:12]})
                    + $signed({{16{r_mean[15]}}, r_mean});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_cache_valid) begin
                        n_state = S_SMUL;
                    end else if (w_ua != 32'd0) begin
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: if (r_cnt == 5'd4) n_state = S_LOG;
            S_LOG:  if (r_cnt == 5'd15) n_state = S_WMUL;
            S_WMUL: n_state = S_SQRT;
            S_SQRT: if (r_cnt == 5'd15) n_state = S_XMUL;
            S_XMUL: n_state = S_ROT;
            S_ROT:  if (w_cdone) n_state = S_SMUL;
            S_SMUL: n_state = S_EMIT;
            S_EMIT: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_cfg_ready = 1'b1;
        o_out_valid = r_out_valid;
        o_out_item  = r_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mean        <= MEAN_RESET;
            r_scale       <= SCALE_RESET;
            r_cache       <= '0;
            r_cache_valid <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MEAN_OFFSET:     r_mean  <= i_cfg_data;
                    REG_DEVIATION_SCALE: r_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept) begin
                        if (r_cache_valid) begin
                            r_z           <= $signed(r_cache);
                            r_from_cache  <= 1'b1;
                            r_cache_valid <= 1'b0;
                        end else begin
                            r_u     <= w_ua;
                            r_lz    <= '0;
                            r_quad  <= w_ub[31:30];
                            r_angle <= w_ub[29:0];
                        end
                    end
                end
                S_NORM: begin
                    r_u  <= w_u_next;
                    r_lz <= w_lz_next;
                    r_m  <= w_u_next[31:1];
                    r_frac <= '0;
                    r_cnt <= (r_cnt == 5'd4) ? 5'd0 : r_cnt + 5'd1;
                end
                S_LOG: begin
                    if (w_sq[61]) begin
                        r_m    <= w_sq[61:31];
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_m    <= w_sq[60:30];
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_WMUL: begin
                    r_rem <= {1'b0, w_wprod[52:22]};
                    r_res <= '0;
                    r_bit <= 32'h4000_0000;
                    r_cnt <= '0;
                end
                S_SQRT: begin
                    if (r_rem >= w_trial) begin
                        r_rem <= r_rem - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                end
                S_ROT: begin
                    if (w_cdone) begin
                        r_cache       <= sat16(w_s);
                        r_cache_valid <= 1'b1;
                        r_z           <= sat16(w_c);
                        r_from_cache  <= 1'b0;
                    end
                end
                S_SMUL: begin
                    r_prod <= r_z * $signed({1'b0, r_scale});
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_item.sample_value <= w_sample;
                        r_out_item.from_cache   <= r_from_cache;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/bmg_checker.sv -----
// Port-level checker for the Gaussian generator core, bound to the top level.
// Depends on bmg_pkg.
module bmg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input bmg_pkg::t_out_item            o_out_item
);
    import bmg_pkg::*;

    logic r_expect_cache;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_cache <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_expect_cache <= !r_expect_cache;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("out item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_item))
        else $error("out item changed while stalled");

    a_alternate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.from_cache == r_expect_cache))
        else $error("generated and cached items out of order");

    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("item emitted without a request in progress");

endmodule

bind box_muller_gaussian_generator_core bmg_checker u_bmg_checker (.*);
